>>> sv/edmrd_pkg.sv
// ----------------------------------------------------------------------------
// edmrd_pkg: shared types and constants of the RGB edge detector
// Payload structs, internal job format, codes and the channel difference.
// ----------------------------------------------------------------------------
package edmrd_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam int CFG_W  = 11;
  localparam int THR_W  = 8;
  localparam int CIDX_W = 2;

  localparam logic [CIDX_W-1:0] REG_THRESHOLD    = 2'd0;
  localparam logic [CIDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [CIDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

  localparam logic [THR_W-1:0] THRESHOLD_RST    = 8'd0;
  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd480;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  localparam logic [23:0] BLACK = 24'h000000;
  localparam logic [23:0] WHITE = 24'hFFFFFF;

  // Micro-operations from the front to its gather stage.
  localparam logic [1:0] OP_PIX = 2'd0;
  localparam logic [1:0] OP_WIN = 2'd1;
  localparam logic [1:0] OP_CAP = 2'd2;

  localparam int QDEPTH = 4;
  localparam int QPW    = 2;
  localparam int QCW    = 3;

  typedef logic [23:0] pixel_t;
  typedef pixel_t [2:0] col_t;   // index 0 top, 1 middle, 2 bottom
  typedef col_t [2:0] blk_t;     // index 0 left, 1 centre, 2 right

  typedef struct packed {
    logic   action;
    pixel_t rgb_pixel;
  } in_item_t;

  typedef struct packed {
    pixel_t out_pixel;
    logic   is_edge;
    logic   last_of_frame;
  } out_item_t;

  typedef struct packed {
    logic left_ok;
    logic right_ok;
    logic top_ok;
    logic bot_ok;
    logic last;
  } nb_flags_t;

  typedef struct packed {
    blk_t      blk;
    nb_flags_t flags;
  } job_t;

  typedef struct packed {
    logic [1:0] op;
    logic       give;
    logic       view_post;
    logic [1:0] cap_idx;
    pixel_t     pix;
    nb_flags_t  flags;
  } s2_op_t;

  function automatic logic [7:0] chan_diff(input pixel_t a, input pixel_t b);
    logic [7:0] best;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] d;
    best = 8'd0;
    for (int s = 0; s < 3; s++) begin
      x = a[s*8 +: 8];
      y = b[s*8 +: 8];
      d = (x > y) ? (x - y) : (y - x);
      if (d > best) best = d;
    end
    return best;
  endfunction

endpackage

>>> sv/edmrd_ram.sv
// ----------------------------------------------------------------------------
// edmrd_ram: generic simple dual-port RAM
// One write port, one read port, registered read returning the old data.
// ----------------------------------------------------------------------------
module edmrd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    rdata <= mem_r[raddr];
  end

endmodule

>>> sv/edmrd_front.sv
// ----------------------------------------------------------------------------
// edmrd_front: input acceptance, position tracking and window gather
// Classifies pixels and flushes, keeps the row stores and the 3x3 window,
// and hands finished neighbourhoods to the job queue.
// ----------------------------------------------------------------------------
module edmrd_front #(
  parameter int MAX_WIDTH  = edmrd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = edmrd_pkg::DEF_MAX_HEIGHT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  edmrd_pkg::in_item_t               in_data,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]    eff_w,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]   eff_h,
  input  logic [edmrd_pkg::QCW-1:0]         q_count,
  output logic                              q_push,
  output edmrd_pkg::job_t                   q_job
);
  import edmrd_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int EWW = $clog2(MAX_WIDTH + 1);
  localparam int EHW = $clog2(MAX_HEIGHT + 1);
  localparam int PW  = $clog2(MAX_WIDTH + 2);
  localparam int XW  = EWW + 1;
  localparam int YW  = EHW + 1;
  localparam int ZW  = PW + 1;

  localparam logic [1:0] ST_RUN = 2'd0;
  localparam logic [1:0] ST_RD1 = 2'd1;
  localparam logic [1:0] ST_RD2 = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] in_col_r, in_col_nxt;
  logic [RW-1:0] in_row_r, in_row_nxt;
  logic [CW-1:0] out_col_r, out_col_nxt;
  logic [RW-1:0] out_row_r, out_row_nxt;
  logic [PW-1:0] pend_r, pend_nxt;
  logic          drain_r, drain_nxt;
  logic [CW-1:0] fl_col_r, fl_col_nxt;
  nb_flags_t     fl_flags_r, fl_flags_nxt;
  logic          s2_v_r, s2_v_nxt;
  s2_op_t        s2_r, s2_nxt;
  logic [CW-1:0] s2_addr_r, s2_addr_nxt;

  logic          fwd_v_r;
  pixel_t        fwd_top_r, fwd_mid_r;
  blk_t          win_r;
  col_t          cap_r [2];

  logic          accept;
  logic [CW-1:0] raddr;
  nb_flags_t     flags;
  logic          oc_wrap, or_wrap, ic_wrap, ir_wrap, last_row;
  logic [ZW-1:0] p_base, p_one;
  logic          give;
  pixel_t        above_rd, cur_rd, top, mid;
  logic          ram_we;
  col_t          col_new;
  blk_t          right_view, post_view;

  assign accept = in_valid && in_ready;
  assign in_ready = (state_r == ST_RUN) &&
                    ((QCW+1)'(q_count) + (QCW+1)'(s2_v_r && s2_r.give) < (QCW+1)'(QDEPTH));

  // Neighbour availability for the oldest pending result.
  always_comb begin
    flags.left_ok  = out_col_r != '0;
    flags.right_ok = (XW'(out_col_r) + XW'(1)) < XW'(eff_w);
    flags.top_ok   = out_row_r != '0;
    flags.bot_ok   = (YW'(out_row_r) + YW'(1)) < YW'(eff_h);
    last_row       = (YW'(out_row_r) + YW'(1)) == YW'(eff_h);
    flags.last     = last_row && ((XW'(out_col_r) + XW'(1)) == XW'(eff_w));
    oc_wrap        = (XW'(out_col_r) + XW'(1)) >= XW'(eff_w);
    or_wrap        = (YW'(out_row_r) + YW'(1)) >= YW'(eff_h);
    ic_wrap        = (XW'(in_col_r) + XW'(1)) >= XW'(eff_w);
    ir_wrap        = (YW'(in_row_r) + YW'(1)) >= YW'(eff_h);
  end

  always_comb begin
    state_nxt    = state_r;
    in_col_nxt   = in_col_r;
    in_row_nxt   = in_row_r;
    out_col_nxt  = out_col_r;
    out_row_nxt  = out_row_r;
    pend_nxt     = pend_r;
    drain_nxt    = drain_r;
    fl_col_nxt   = fl_col_r;
    fl_flags_nxt = fl_flags_r;
    s2_v_nxt     = 1'b0;
    s2_nxt       = '0;
    s2_addr_nxt  = in_col_r;
    raddr        = in_col_r;
    p_base       = drain_r ? '0 : ZW'(pend_r);
    p_one        = p_base + ZW'(1);
    give         = p_one > (ZW'(eff_w) + ZW'(1));

    case (state_r)
      ST_RUN: begin
        if (accept) begin
          if (in_data.action == ACT_PIXEL) begin
            drain_nxt  = 1'b0;
            pend_nxt   = give ? PW'(p_one - ZW'(1)) : PW'(p_one);
            in_col_nxt = ic_wrap ? '0 : in_col_r + CW'(1);
            if (ic_wrap) in_row_nxt = ir_wrap ? '0 : in_row_r + RW'(1);
            if (give) begin
              out_col_nxt = oc_wrap ? '0 : out_col_r + CW'(1);
              if (oc_wrap) out_row_nxt = or_wrap ? '0 : out_row_r + RW'(1);
            end
            s2_v_nxt         = 1'b1;
            s2_nxt.op        = OP_PIX;
            s2_nxt.give      = give;
            s2_nxt.view_post = in_col_r != '0;
            s2_nxt.pix       = in_data.rgb_pixel;
            s2_nxt.flags     = flags;
          end else if (pend_r != '0 && in_col_r == '0 && in_row_r == '0) begin
            pend_nxt    = pend_r - PW'(1);
            drain_nxt   = pend_r != PW'(1);
            out_col_nxt = oc_wrap ? '0 : out_col_r + CW'(1);
            if (oc_wrap) out_row_nxt = or_wrap ? '0 : out_row_r + RW'(1);
            s2_v_nxt     = 1'b1;
            s2_nxt.flags = flags;
            if (last_row) begin
              // Bottom row: the neighbourhood comes from the row stores, one
              // column per cycle through the single read port.
              s2_nxt.op      = OP_CAP;
              s2_nxt.cap_idx = 2'd0;
              raddr          = out_col_r - CW'(1);
              fl_col_nxt     = out_col_r;
              fl_flags_nxt   = flags;
              state_nxt      = ST_RD1;
            end else begin
              s2_nxt.op   = OP_WIN;
              s2_nxt.give = 1'b1;
            end
          end
        end
      end
      ST_RD1: begin
        raddr          = fl_col_r;
        s2_v_nxt       = 1'b1;
        s2_nxt.op      = OP_CAP;
        s2_nxt.cap_idx = 2'd1;
        state_nxt      = ST_RD2;
      end
      ST_RD2: begin
        raddr          = fl_col_r + CW'(1);
        s2_v_nxt       = 1'b1;
        s2_nxt.op      = OP_CAP;
        s2_nxt.cap_idx = 2'd2;
        s2_nxt.give    = 1'b1;
        s2_nxt.flags   = fl_flags_r;
        state_nxt      = ST_RUN;
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_RUN;
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      pend_r    <= '0;
      drain_r   <= 1'b0;
      s2_v_r    <= 1'b0;
      fwd_v_r   <= 1'b0;
      win_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      pend_r    <= pend_nxt;
      drain_r   <= drain_nxt;
      s2_v_r    <= s2_v_nxt;
      fwd_v_r   <= ram_we && (s2_addr_r == raddr);
      if (ram_we) begin
        win_r[0] <= win_r[1];
        win_r[1] <= win_r[2];
        win_r[2] <= col_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    fl_col_r   <= fl_col_nxt;
    fl_flags_r <= fl_flags_nxt;
    s2_r       <= s2_nxt;
    s2_addr_r  <= s2_addr_nxt;
    fwd_top_r  <= mid;
    fwd_mid_r  <= s2_r.pix;
    if (s2_v_r && s2_r.op == OP_CAP && s2_r.cap_idx == 2'd0) cap_r[0] <= col_new;
    if (s2_v_r && s2_r.op == OP_CAP && s2_r.cap_idx == 2'd1) cap_r[1] <= col_new;
  end

  edmrd_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_above (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s2_addr_r),
    .wdata (mid),
    .raddr (raddr),
    .rdata (above_rd)
  );

  edmrd_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_current (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s2_addr_r),
    .wdata (s2_r.pix),
    .raddr (raddr),
    .rdata (cur_rd)
  );

  // A read that met a write to the same column last cycle takes the new data.
  assign top    = fwd_v_r ? fwd_top_r : above_rd;
  assign mid    = fwd_v_r ? fwd_mid_r : cur_rd;
  assign ram_we = s2_v_r && (s2_r.op == OP_PIX);

  always_comb begin
    col_new[0] = top;
    col_new[1] = mid;
    col_new[2] = (s2_r.op == OP_PIX) ? s2_r.pix : '0;

    right_view[0] = win_r[1];
    right_view[1] = win_r[2];
    right_view[2] = win_r[2];

    post_view[0] = win_r[1];
    post_view[1] = win_r[2];
    post_view[2] = col_new;

    q_push      = s2_v_r && s2_r.give;
    q_job.flags = s2_r.flags;
    case (s2_r.op)
      OP_PIX:  q_job.blk = s2_r.view_post ? post_view : right_view;
      OP_WIN:  q_job.blk = right_view;
      OP_CAP: begin
        q_job.blk[0] = cap_r[0];
        q_job.blk[1] = cap_r[1];
        q_job.blk[2] = col_new;
      end
      default: q_job.blk = right_view;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_RUN) |-> !in_ready)
    else $error("input taken during a row store drain read");
  a_read_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD1) |=> (state_r == ST_RD2))
    else $error("drain read sequence broken");
`endif

endmodule

>>> sv/edmrd_queue.sv
// ----------------------------------------------------------------------------
// edmrd_queue: short job queue between gather and compare
// Holds complete neighbourhoods so that each side can stall on its own.
// ----------------------------------------------------------------------------
module edmrd_queue (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  edmrd_pkg::job_t           push_job,
  input  logic                      pop,
  output logic                      head_valid,
  output edmrd_pkg::job_t           head_job,
  output logic [edmrd_pkg::QCW-1:0] count
);
  import edmrd_pkg::*;

  job_t           mem_r [QDEPTH];
  logic [QPW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPW'(1);
      count_r <= count_r + QCW'(push) - QCW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

  assign head_valid = count_r != '0;
  assign head_job   = mem_r[rd_ptr_r];
  assign count      = count_r;

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r < QCW'(QDEPTH)))
    else $error("job queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("job queue underflow");
`endif

endmodule

>>> sv/edmrd_back.sv
// ----------------------------------------------------------------------------
// edmrd_back: neighbour difference and threshold decision
// Two pipeline stages: per-neighbour channel differences, then the maximum
// against the threshold into the output register.
// ----------------------------------------------------------------------------
module edmrd_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [edmrd_pkg::THR_W-1:0]   threshold,
  input  logic                          q_valid,
  input  edmrd_pkg::job_t               q_job,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output edmrd_pkg::out_item_t          out_data
);
  import edmrd_pkg::*;

  logic             a_v_r;
  logic [8:0][7:0]  a_d_r;
  logic             a_last_r;
  logic             o_v_r;
  out_item_t        o_r;
  logic [8:0][7:0]  d_nxt;
  logic [7:0]       best;
  logic             edge_hit;
  logic             a_load, o_load;
  logic             en;

  assign o_load = a_v_r && (!o_v_r || out_ready);
  assign a_load = q_valid && (!a_v_r || o_load);
  assign q_pop  = a_load;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int l = 0; l < 3; l++) begin
        en = (k != 0 || q_job.flags.left_ok) && (k != 2 || q_job.flags.right_ok) &&
             (l != 0 || q_job.flags.top_ok)  && (l != 2 || q_job.flags.bot_ok);
        d_nxt[k*3+l] = en ? chan_diff(q_job.blk[1][1], q_job.blk[k][l]) : 8'd0;
      end
    end
  end

  always_comb begin
    best = 8'd0;
    for (int i = 0; i < 9; i++) begin
      if (a_d_r[i] > best) best = a_d_r[i];
    end
    edge_hit = best > threshold;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (a_load)      a_v_r <= 1'b1;
      else if (o_load) a_v_r <= 1'b0;
      if (o_load)         o_v_r <= 1'b1;
      else if (out_ready) o_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_d_r    <= d_nxt;
      a_last_r <= q_job.flags.last;
    end
    if (o_load) begin
      o_r.out_pixel     <= edge_hit ? BLACK : WHITE;
      o_r.is_edge       <= edge_hit;
      o_r.last_of_frame <= a_last_r;
    end
  end

  assign out_valid = o_v_r;
  assign out_data  = o_r;

endmodule

>>> sv/edge_detect_max_rgb_diff_unit.sv
// ----------------------------------------------------------------------------
// edge_detect_max_rgb_diff_unit: streaming 3x3 RGB edge detector
// Marks a pixel black when some in-frame neighbour differs from it in one
// color channel by more than the threshold, white otherwise.
// ----------------------------------------------------------------------------
// The unit takes one pixel per clock while the job queue has room and no bottom
// row flush read is under way; each result leaves frame_width plus one input
// transactions after its pixel, through the row store read, gather, job queue,
// difference stage and output register. A flush transaction on the bottom row
// stalls the input through the RD1 and RD2 read states, because its neighbourhood
// is read back from the two row stores one column per clock through their
// single read port. The row stores need no clearing pass.
module edge_detect_max_rgb_diff_unit #(
  parameter int MAX_WIDTH  = edmrd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = edmrd_pkg::DEF_MAX_HEIGHT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  edmrd_pkg::in_item_t            in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output edmrd_pkg::out_item_t           out_data,
  input  logic                           cfg_we,
  input  logic [edmrd_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [edmrd_pkg::CFG_W-1:0]    cfg_wdata
);
  import edmrd_pkg::*;

  localparam int EWW  = $clog2(MAX_WIDTH + 1);
  localparam int EHW  = $clog2(MAX_HEIGHT + 1);
  localparam int CMPW = (EWW > CFG_W) ? EWW : CFG_W;
  localparam int CMPH = (EHW > CFG_W) ? EHW : CFG_W;

  logic [THR_W-1:0] threshold_r;
  logic [CFG_W-1:0] frame_width_r;
  logic [CFG_W-1:0] frame_height_r;
  logic [EWW-1:0]   eff_w;
  logic [EHW-1:0]   eff_h;
  logic             q_push, q_pop, q_valid;
  job_t             push_job, head_job;
  logic [QCW-1:0]   q_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r    <= THRESHOLD_RST;
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD:    threshold_r    <= cfg_wdata[THR_W-1:0];
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata;
        REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sizes in use: zero acts as one, anything above the maximum as the maximum.
  always_comb begin
    if (frame_width_r == '0)                      eff_w = EWW'(1);
    else if (CMPW'(frame_width_r) > CMPW'(MAX_WIDTH)) eff_w = EWW'(MAX_WIDTH);
    else                                          eff_w = EWW'(frame_width_r);
    if (frame_height_r == '0)                       eff_h = EHW'(1);
    else if (CMPH'(frame_height_r) > CMPH'(MAX_HEIGHT)) eff_h = EHW'(MAX_HEIGHT);
    else                                            eff_h = EHW'(frame_height_r);
  end

  edmrd_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .eff_w    (eff_w),
    .eff_h    (eff_h),
    .q_count  (q_count),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  edmrd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (push_job),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_job   (head_job),
    .count      (q_count)
  );

  edmrd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .threshold (threshold_r),
    .q_valid   (q_valid),
    .q_job     (head_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> dv/edge_detect_max_rgb_diff_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_detect_max_rgb_diff_unit_checker: result predictor and scoreboard
// Mirrors the configuration writes, predicts the edge decision of every
// accepted input transaction and compares each output transaction, in order,
// against the oldest predicted result.
// ----------------------------------------------------------------------------
module edge_detect_max_rgb_diff_unit_checker
  import edmrd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  in_item_t            in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  out_item_t           out_data,
  input  logic                cfg_we,
  input  logic [CIDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]    cfg_wdata,
  output int                  errors,
  output int                  results_owed
);

  localparam int STORE_DEPTH = DEF_MAX_WIDTH;

  pixel_t      above_row [STORE_DEPTH];
  pixel_t      current_row [STORE_DEPTH];
  blk_t        win;
  int unsigned in_col, in_line, out_col, out_line, backlog;
  bit          drain_started;
  logic [7:0]  thr;
  logic [10:0] fw, fh;
  out_item_t   owed_q [$];

  function automatic int unsigned clamp_size(logic [10:0] v, int unsigned top);
    if (v == 0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  function automatic logic [7:0] widest_channel_gap(pixel_t a, pixel_t b);
    logic [7:0] best;
    logic [7:0] d;
    best = 0;
    for (int c = 0; c < 3; c++) begin
      d = (a[c*8 +: 8] > b[c*8 +: 8]) ? a[c*8 +: 8] - b[c*8 +: 8]
                                      : b[c*8 +: 8] - a[c*8 +: 8];
      if (d > best) best = d;
    end
    return best;
  endfunction

  // Judges the pixel at the output position from a block centered at b[1][1].
  function automatic out_item_t judge_pixel(blk_t b);
    int unsigned w;
    int unsigned h;
    logic [7:0]  best;
    logic [7:0]  d;
    bit          edge_hit;
    out_item_t   r;
    w = clamp_size(fw, DEF_MAX_WIDTH);
    h = clamp_size(fh, DEF_MAX_HEIGHT);
    best = 0;
    for (int k = 0; k < 3; k++) begin
      if ((k == 0 && out_col == 0) || (k == 2 && out_col + 1 >= w)) continue;
      for (int l = 0; l < 3; l++) begin
        if ((l == 0 && out_line == 0) || (l == 2 && out_line + 1 >= h)) continue;
        d = widest_channel_gap(b[1][1], b[k][l]);
        if (d > best) best = d;
      end
    end
    edge_hit = best > thr;
    r.out_pixel = edge_hit ? BLACK : WHITE;
    r.is_edge = edge_hit;
    r.last_of_frame = (out_line + 1 == h) && (out_col + 1 == w);
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_line++;
      if (out_line >= h) out_line = 0;
    end
    return r;
  endfunction

  function automatic out_item_t judge_right_edge();
    blk_t b;
    for (int l = 0; l < 3; l++) begin
      b[0][l] = win[1][l];
      b[1][l] = win[2][l];
      b[2][l] = win[2][l];
    end
    return judge_pixel(b);
  endfunction

  function automatic pixel_t store_at(bit upper, int unsigned idx);
    if (idx >= STORE_DEPTH) return '0;
    return upper ? above_row[idx] : current_row[idx];
  endfunction

  function automatic bit predict_edge(in_item_t it, output out_item_t r);
    int unsigned w;
    int unsigned h;
    int unsigned ic;
    int unsigned idx;
    pixel_t      top;
    pixel_t      mid;
    blk_t        b;
    bit          give;
    w = clamp_size(fw, DEF_MAX_WIDTH);
    h = clamp_size(fh, DEF_MAX_HEIGHT);
    r = '0;
    if (it.action == ACT_FLUSH) begin
      if (backlog == 0 || in_line != 0 || in_col != 0) return 0;
      if (out_line + 1 == h) begin
        // Bottom row: the neighborhood comes back out of the row stores.
        for (int k = 0; k < 3; k++) begin
          idx = out_col + k - 1;
          b[k][0] = (k == 0 && out_col == 0) ? '0 : store_at(1, idx);
          b[k][1] = (k == 0 && out_col == 0) ? '0 : store_at(0, idx);
          b[k][2] = '0;
        end
        r = judge_pixel(b);
      end else begin
        r = judge_right_edge();
      end
      backlog--;
      drain_started = backlog > 0;
      return 1;
    end
    if (drain_started) begin
      backlog = 0;
      drain_started = 0;
    end
    ic = in_col;
    top = store_at(1, ic);
    mid = store_at(0, ic);
    if (ic < STORE_DEPTH) begin
      above_row[ic] = mid;
      current_row[ic] = it.rgb_pixel;
    end
    backlog++;
    give = backlog > w + 1;
    if (give && ic == 0) r = judge_right_edge();
    for (int l = 0; l < 3; l++) begin
      win[0][l] = win[1][l];
      win[1][l] = win[2][l];
    end
    win[2][0] = top;
    win[2][1] = mid;
    win[2][2] = it.rgb_pixel;
    if (give && ic != 0) r = judge_pixel(win);
    if (give) backlog--;
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_line++;
      if (in_line >= h) in_line = 0;
    end
    return give;
  endfunction

  initial begin
    errors = 0;
    results_owed = 0;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      above_row[i] = '0;
      current_row[i] = '0;
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (!rst_n) begin
      thr = THRESHOLD_RST;
      fw = FRAME_WIDTH_RST;
      fh = FRAME_HEIGHT_RST;
      win = '0;
      in_col = 0;
      in_line = 0;
      out_col = 0;
      out_line = 0;
      backlog = 0;
      drain_started = 0;
      owed_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (owed_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %h", $time, out_data);
        end else begin
          want = owed_q.pop_front();
          if (out_data.out_pixel !== want.out_pixel) begin
            errors++;
            $display("%0t: out_pixel expected %h actual %h", $time,
                     want.out_pixel, out_data.out_pixel);
          end
          if (out_data.is_edge !== want.is_edge) begin
            errors++;
            $display("%0t: is_edge expected %b actual %b", $time,
                     want.is_edge, out_data.is_edge);
          end
          if (out_data.last_of_frame !== want.last_of_frame) begin
            errors++;
            $display("%0t: last_of_frame expected %b actual %b", $time,
                     want.last_of_frame, out_data.last_of_frame);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_THRESHOLD:    thr = cfg_wdata[7:0];
          REG_FRAME_WIDTH:  fw = cfg_wdata;
          REG_FRAME_HEIGHT: fh = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (predict_edge(in_data, got)) owed_q.push_back(got);
      end
    end
    results_owed = owed_q.size();
  end

endmodule

>>> dv/edge_detect_max_rgb_diff_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_detect_max_rgb_diff_unit_tb: regression bench of the RGB edge detector
// Streams whole frames of mixed pixels over many geometries and thresholds,
// with flushes, interrupted drains and random idling on both channels.
// ----------------------------------------------------------------------------
module edge_detect_max_rgb_diff_unit_tb;
  import edmrd_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE = 24;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  in_item_t           in_data;
  logic               out_valid;
  logic               out_ready;
  out_item_t          out_data;
  logic               cfg_we;
  logic [CIDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]   cfg_wdata;
  int                 errors;
  int                 results_owed;
  int                 cycles;
  int                 send_gap_pct;
  int                 stall_pct;
  bit                 hold_off;
  int                 pixels_sent;
  pixel_t             base_pix;

  edge_detect_max_rgb_diff_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  edge_detect_max_rgb_diff_unit_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .errors(errors), .results_owed(results_owed)
  );

  initial clk = 0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("edge_detect_max_rgb_diff_unit regression: fail");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send(logic act, pixel_t pix);
    bit taken;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{action: act, rgb_pixel: pix};
    if (act == ACT_PIXEL) pixels_sent++;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
    // The last input transaction was taken already; offer nothing more.
    in_valid <= 1'b0;
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (results_owed != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic pixel_t pick_pixel();
    case ($urandom_range(3))
      0: return $urandom;
      1: return base_pix ^ ($urandom & 24'h1F1F1F);
      2: return base_pix;
      default: return $urandom_range(1) ? WHITE : BLACK;
    endcase
  endfunction

  function automatic int unsigned used_size(logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > 1024) return 1024;
    return v;
  endfunction

  task automatic send_frame(int unsigned w, int unsigned h, bit stray_flushes);
    base_pix = $urandom;
    for (int unsigned i = 0; i < w * h; i++) begin
      // A flush inside a frame must be ignored.
      if (stray_flushes && i > 0 && $urandom_range(19) == 0) send(ACT_FLUSH, $urandom);
      send(ACT_PIXEL, pick_pixel());
    end
  endtask

  task automatic flush_n(int unsigned n);
    repeat (n) send(ACT_FLUSH, $urandom);
  endtask

  // Sets the threshold and geometry, runs frames back to back and drains the last one.
  task automatic run_frames(logic [CFG_W-1:0] w_reg, logic [CFG_W-1:0] h_reg,
                            logic [7:0] thr_val, int frames);
    int unsigned w;
    int unsigned h;
    w = used_size(w_reg);
    h = used_size(h_reg);
    write_reg(REG_THRESHOLD, {3'b000, thr_val});
    write_reg(REG_FRAME_WIDTH, w_reg);
    write_reg(REG_FRAME_HEIGHT, h_reg);
    for (int f = 0; f < frames; f++) begin
      send_frame(w, h, 1);
      // Sometimes start draining, then cut the drain short with a new frame.
      if (f < frames - 1 && $urandom_range(2) == 0) flush_n($urandom_range(1, w));
    end
    flush_n(w + 1);
    wait_drained();
  endtask

  task automatic random_phase(int gap, int stall, int quota);
    int          target;
    logic [CFG_W-1:0] wr;
    logic [CFG_W-1:0] hr;
    logic [7:0]  t;
    send_gap_pct = gap;
    stall_pct = stall;
    target = pixels_sent + quota;
    while (pixels_sent < target) begin
      case ($urandom_range(9))
        0: wr = 1;
        1: wr = 2;
        2: wr = 3;
        8: wr = $urandom_range(13, 40);
        9: wr = 0;
        default: wr = $urandom_range(4, 12);
      endcase
      hr = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 5);
      case ($urandom_range(5))
        0: t = 0;
        1: t = 255;
        2: t = $urandom;
        default: t = $urandom_range(0, 40);
      endcase
      run_frames(wr, hr, t, $urandom_range(1, 3));
    end
  endtask

  initial begin
    cycles = 0;
    send_gap_pct = 0;
    stall_pct = 0;
    hold_off = 0;
    pixels_sent = 0;
    base_pix = '0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_THRESHOLD;
    cfg_wdata <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A flush with nothing pending does nothing.
    send(ACT_FLUSH, WHITE);
    // A wide two-row frame at the lowest threshold.
    run_frames(11'd40, 11'd2, 8'd0, 1);

    // Directed: extreme pixels on a 3x3 frame at both threshold extremes.
    write_reg(REG_THRESHOLD, 11'd255);
    write_reg(REG_FRAME_WIDTH, 11'd3);
    write_reg(REG_FRAME_HEIGHT, 11'd3);
    send(ACT_PIXEL, BLACK);
    send(ACT_FLUSH, BLACK);
    for (int i = 1; i < 9; i++) send(ACT_PIXEL, (i % 2) ? WHITE : BLACK);
    flush_n(4);
    wait_drained();
    write_reg(REG_THRESHOLD, 11'd0);
    for (int i = 0; i < 9; i++) send(ACT_PIXEL, (i == 4) ? 24'h010000 : BLACK);
    flush_n(4);
    wait_drained();
    // Single-pixel frame from zero size registers; the extra flush returns nothing.
    write_reg(REG_FRAME_WIDTH, 11'd0);
    write_reg(REG_FRAME_HEIGHT, 11'd0);
    send(ACT_PIXEL, 24'h123456);
    flush_n(2);
    wait_drained();
    // Tall frame, one column wide.
    run_frames(11'd1, 11'd64, 8'd20, 1);

    random_phase(0, 0, 200);
    // The receiver holds off while the sender keeps pushing.
    hold_off = 1;
    run_frames(11'd16, 11'd4, 8'd16, 2);
    random_phase(58, 0, 200);
    random_phase(0, 58, 200);
    random_phase(33, 33, 200);

    send_gap_pct = 0;
    stall_pct = 0;
    wait_drained();
    if (errors == 0) begin
      $display("edge_detect_max_rgb_diff_unit regression: pass");
    end else begin
      $display("edge_detect_max_rgb_diff_unit regression: fail");
    end
    $finish;
  end

endmodule
